/* design/nfs_pkg.sv */
// shared types, codes and frame helpers for the nixie frame and acp sequencer
`default_nettype none

package nfs_pkg;

    localparam int DigitCount = 6;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_DIGITS = 2'd1;
    localparam logic [1:0] CMD_DOTS   = 2'd2;

    localparam logic [1:0] MODE_NONE      = 2'd0;
    localparam logic [1:0] MODE_SINGLES   = 2'd1;
    localparam logic [1:0] MODE_PER_DIGIT = 2'd2;
    localparam logic [1:0] MODE_ROTATE    = 2'd3;

    localparam logic [1:0] REG_ACP_MODE       = 2'd0;
    localparam logic [1:0] REG_CYCLE_INTERVAL = 2'd1;
    localparam logic [1:0] REG_STEP_INTERVAL  = 2'd2;
    localparam logic [1:0] REG_MIN_UPDATE     = 2'd3;

    localparam logic [15:0] MIN_UPDATE_RESET = 16'd100;

    localparam logic [3:0] ROTATE_ADD [DigitCount] = '{4'd0, 4'd3, 4'd6, 4'd9, 4'd2, 4'd5};

    typedef struct packed {
        logic [31:0] now_ms;
        logic [63:0] shown_frame;
        logic [63:0] last_sent_frame;
        logic [31:0] last_send_time;
        logic        acp_active;
        logic [31:0] next_cycle_time;
        logic [31:0] next_step_time;
        logic [9:0]  acp_position;
    } state_t;

    typedef struct packed {
        logic [1:0]  acp_mode;
        logic [31:0] acp_cycle_interval;
        logic [31:0] acp_step_interval;
        logic [15:0] min_update_interval;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                 cmd;
        logic [DigitCount-1:0][3:0] digit;
        logic [3:0]                 dots;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] frame;
        logic        is_acp;
    } result_t;

    function automatic logic [9:0] digit_code(input logic [3:0] val);
        logic [9:0] code;
        code = '0;
        if (val < 4'd10)
        begin
            code = 10'd1 << val;
        end
        return code;
    endfunction

    function automatic logic [63:0] put_digit(input logic [63:0] f, input logic [3:0] pos,
                                              input logic [3:0] val);
        logic [63:0] r;
        r = f;
        unique case (pos)
            4'd0: r[9:0]   = digit_code(val);
            4'd1: r[19:10] = digit_code(val);
            4'd2: r[29:20] = digit_code(val);
            4'd3: r[41:32] = digit_code(val);
            4'd4: r[51:42] = digit_code(val);
            4'd5: r[61:52] = digit_code(val);
            default: ;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/nixie_frame_and_acp_sequencer.sv */
// top level: input register, sequencer state, configuration and output register
// an accepted transaction is held in the input register and its result, if any, in the output register
// throughput: one transaction per cycle while m_tready is high, set by the single
// registered pass through the step logic
// s_tready drops only while the output register holds a result that is not taken
// reset: asynchronous active low, clears state, configuration and both valid flags
`default_nettype none

module nixie_frame_and_acp_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // digit_0 .. digit_5 (4 bits each), dots (4), zero pad
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // frame
    output logic [0:0]  m_tuser,   // is_acp_frame
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import nfs_pkg::*;

    logic        in_valid_reg;
    logic [1:0]  in_cmd_reg;
    logic [27:0] in_data_reg;
    state_t      state_reg;
    state_t      state_next;
    cfg_t        cfg_reg;
    logic        out_valid_reg;
    logic [63:0] out_frame_reg;
    logic        out_acp_reg;
    item_t       item;
    result_t     res;
    logic        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign item.cmd   = in_cmd_reg;
    assign item.digit = in_data_reg[23:0];
    assign item.dots  = in_data_reg[27:24];

    nfs_step u_step (
        .st      (state_reg),
        .cfg     (cfg_reg),
        .item    (item),
        .st_next (state_next),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.acp_mode            <= MODE_NONE;
            cfg_reg.acp_cycle_interval  <= '0;
            cfg_reg.acp_step_interval   <= '0;
            cfg_reg.min_update_interval <= MIN_UPDATE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ACP_MODE:       cfg_reg.acp_mode            <= cfg_data[1:0];
                REG_CYCLE_INTERVAL: cfg_reg.acp_cycle_interval  <= cfg_data;
                REG_STEP_INTERVAL:  cfg_reg.acp_step_interval   <= cfg_data;
                REG_MIN_UPDATE:     cfg_reg.min_update_interval <= cfg_data[15:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= res.valid;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg  <= s_tuser;
            in_data_reg <= s_tdata[27:0];
        end
        if (advance && res.valid)
        begin
            out_frame_reg <= res.frame;
            out_acp_reg   <= res.is_acp;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_frame_reg;
    assign m_tuser[0] = out_acp_reg;

endmodule

`default_nettype wire

/* design/nfs_step.sv */
// next-state and result logic for one transaction of the sequencer
`default_nettype none

module nfs_step (
    input  nfs_pkg::state_t  st,
    input  nfs_pkg::cfg_t    cfg,
    input  nfs_pkg::item_t   item,
    output nfs_pkg::state_t  st_next,
    output nfs_pkg::result_t res
);
    import nfs_pkg::*;

    logic [31:0] now;
    logic [9:0]  p;
    logic        start;
    logic [31:0] nst;

    logic [19:0] prod100;
    logic [3:0]  d100;
    logic [9:0]  v100;
    logic [3:0]  dn;
    logic [3:0]  dw;
    logic [9:0]  wrap_pos;

    logic [13:0] prod10;
    logic [2:0]  d10;
    logic [5:0]  v10;

    logic [63:0] rot_frame;
    logic [31:0] since_send;

    assign now   = st.now_ms + 32'd1;
    assign p     = st.acp_position;
    assign start = !st.acp_active && (cfg.acp_mode != MODE_NONE) && (st.next_cycle_time <= now);
    assign nst   = start ? now : st.next_step_time;

    // p / 100 by reciprocal, exact for every 10-bit position
    assign prod100  = 20'(p) * 20'd656;
    assign d100     = prod100[19:16];
    assign v100     = p - (10'(d100) * 10'd100);
    assign dn       = d100 + 4'd1;
    assign dw       = (dn >= 4'd6) ? (dn - 4'd6) : dn;
    assign wrap_pos = 10'(dw) * 10'd100;

    // p / 10 by reciprocal, used for positions below sixty
    assign prod10 = 14'(p[5:0]) * 14'd205;
    assign d10    = prod10[13:11];
    assign v10    = p[5:0] - (6'(d10) * 6'd10);

    assign since_send = now - st.last_send_time;

    always_comb
    begin
        logic [4:0] sum;
        rot_frame = st.shown_frame;
        for (int i = 0; i < DigitCount; i++)
        begin
            sum = 5'(p[3:0]) + 5'(ROTATE_ADD[i]);
            if (sum >= 5'd10)
            begin
                sum = sum - 5'd10;
            end
            rot_frame = put_digit(rot_frame, 4'(i), sum[3:0]);
        end
    end

    always_comb
    begin
        st_next = st;
        res     = '0;
        unique case (item.cmd)
            CMD_DIGITS:
            begin
                for (int i = 0; i < DigitCount; i++)
                begin
                    st_next.shown_frame = put_digit(st_next.shown_frame, 4'(i), item.digit[i]);
                end
            end
            CMD_DOTS:
            begin
                st_next.shown_frame[30] = item.dots[0];
                st_next.shown_frame[31] = item.dots[1];
                st_next.shown_frame[62] = item.dots[2];
                st_next.shown_frame[63] = item.dots[3];
            end
            CMD_TICK:
            begin
                st_next.now_ms = now;
                if (st.acp_active || start)
                begin
                    if (start)
                    begin
                        st_next.last_sent_frame = ~st.shown_frame;
                        st_next.next_cycle_time = now + cfg.acp_cycle_interval;
                        st_next.acp_active      = 1'b1;
                        st_next.next_step_time  = now;
                    end
                    if (cfg.acp_mode == MODE_NONE)
                    begin
                        st_next.acp_active = 1'b0;
                    end
                    else if (nst <= now)
                    begin
                        unique case (cfg.acp_mode)
                            MODE_SINGLES:
                            begin
                                if (p > 10'd59)
                                begin
                                    st_next.acp_position = '0;
                                    st_next.acp_active   = 1'b0;
                                end
                                else
                                begin
                                    st_next.next_step_time = nst + cfg.acp_step_interval;
                                    st_next.acp_position   = p + 10'd1;
                                    res.valid  = 1'b1;
                                    res.is_acp = 1'b1;
                                    res.frame  = put_digit(st.shown_frame, 4'(d10), v10[3:0]);
                                end
                            end
                            MODE_PER_DIGIT:
                            begin
                                st_next.next_step_time = nst + cfg.acp_step_interval;
                                if (v100 > 10'd9)
                                begin
                                    st_next.acp_position = wrap_pos;
                                    st_next.acp_active   = 1'b0;
                                end
                                else
                                begin
                                    st_next.acp_position = p + 10'd1;
                                    res.valid  = 1'b1;
                                    res.is_acp = 1'b1;
                                    res.frame  = put_digit(st.shown_frame, d100, v100[3:0]);
                                end
                            end
                            MODE_ROTATE:
                            begin
                                if (p > 10'd9)
                                begin
                                    st_next.acp_position = '0;
                                    st_next.acp_active   = 1'b0;
                                end
                                else
                                begin
                                    st_next.next_step_time = nst + cfg.acp_step_interval;
                                    st_next.acp_position   = p + 10'd1;
                                    res.valid  = 1'b1;
                                    res.is_acp = 1'b1;
                                    res.frame  = rot_frame;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                else if ((st.shown_frame != st.last_sent_frame) &&
                         (since_send >= 32'(cfg.min_update_interval)))
                begin
                    st_next.last_sent_frame = st.shown_frame;
                    st_next.last_send_time  = now;
                    res.valid  = 1'b1;
                    res.is_acp = 1'b0;
                    res.frame  = st.shown_frame;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* design/nfs_checker.sv */
// port-level checker for the sequencer and its bind
`default_nettype none

module nfs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

    // input back-pressure only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
    else $error("s_tready low without output stall");

    // a new result follows an accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without accepted transaction");

endmodule

bind nixie_frame_and_acp_sequencer nfs_checker u_nfs_checker (.*);

`default_nettype wire
